[design/adof_pkg.sv]
// Package: shared constants, word types and mode codes for the distinct/dupes filter.
`timescale 1ns / 1ps

package adof_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int VALUE_WIDTH_DEF = 64;
    localparam int ELEM_WIDTH      = 64;
    localparam int CNT_WIDTH       = 16;
    localparam int NULL_CNT_W      = 2;
    localparam int NULL_KEEP_DUPES = 2;

    typedef logic [CNT_WIDTH-1:0]  t_cnt;
    typedef logic [NULL_CNT_W-1:0] t_null_cnt;

    localparam t_cnt CNT_MAX = '1;

    localparam logic MODE_DISTINCT = 1'b0;
    localparam logic MODE_DUPES    = 1'b1;

    // control part of a word travelling down the cell row
    typedef struct packed {
        logic vld;
        logic nul;
        logic last;
        logic dupes;
        logic res;
        logic keep;
    } t_tok;

    typedef struct packed {
        logic keep;
        t_cnt pos;
        t_cnt kept;
        logic done;
        logic ovf;
    } t_res;

endpackage

[design/adof_if.sv]
// Interfaces: element, result and mode-write channels with valid/ready handshake.
`timescale 1ns / 1ps

interface adof_elem_if;
    logic                                        valid;
    logic                                        ready;
    logic signed [adof_pkg::ELEM_WIDTH-1:0]      element_value;
    logic                                        element_is_null;
    logic                                        last_in_array;

    modport source (output valid, element_value, element_is_null, last_in_array,
                    input ready);
    modport sink   (input valid, element_value, element_is_null, last_in_array,
                    output ready);
endinterface

interface adof_res_if;
    logic                          valid;
    logic                          ready;
    logic                          keep_element;
    logic [adof_pkg::CNT_WIDTH-1:0] element_position;
    logic [adof_pkg::CNT_WIDTH-1:0] kept_so_far;
    logic                          array_done;
    logic                          table_overflow;

    modport source (output valid, keep_element, element_position, kept_so_far,
                    array_done, table_overflow, input ready);
    modport sink   (input valid, keep_element, element_position, kept_so_far,
                    array_done, table_overflow, output ready);
endinterface

interface adof_cfg_if;
    logic valid;
    logic ready;
    logic mode_select;

    modport source (output valid, mode_select, input ready);
    modport sink   (input valid, mode_select, output ready);
endinterface

[design/array_distinct_or_dupes_filter.sv]
// Top level: streaming distinct/dupes filter built as a row of table cells.
//
// Usage
//   i_elem  : one array element per word (value, null flag, last-in-array flag).
//   o_res   : one result word per element, in order: keep flag, position,
//             kept count including this element, array end, table overflow.
//   i_cfg   : writes mode_select (0 distinct, 1 dupes); write only while idle.
//   Each element walks the row of TABLE_DEPTH cells, one cell per cycle; a
//   cell either matches it, takes it into an empty slot, or passes it on.
//   The last element of an array clears each cell as it passes.
//   Path: TABLE_DEPTH cell registers, then the result register, to o_res.
//   Throughput: one element per cycle unless the row is stalled.
//   Stall: when a result waits and o_res.ready is low, the whole row holds
//   and i_elem.ready drops in the same cycle; nothing is lost.
//   Reset: all cells empty, counters zero, mode distinct. No clearing pass.
//   i_cfg.ready is always high.
`timescale 1ns / 1ps

module array_distinct_or_dupes_filter #(
    parameter int TABLE_DEPTH = adof_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = adof_pkg::VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    adof_elem_if.sink   i_elem,
    adof_cfg_if.sink    i_cfg,
    adof_res_if.source  o_res
);

    logic                   r_mode;
    logic                   w_adv;
    logic                   w_out_vld;
    adof_pkg::t_res         w_res;
    adof_pkg::t_tok         w_tok [TABLE_DEPTH+1];
    logic [VALUE_WIDTH-1:0] w_val [TABLE_DEPTH+1];

    assign w_adv        = !w_out_vld || o_res.ready;
    assign i_elem.ready = w_adv;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= adof_pkg::MODE_DISTINCT;
        end else if (i_cfg.valid) begin
            r_mode <= i_cfg.mode_select;
        end
    end

    always_comb begin
        w_tok[0].vld   = i_elem.valid;
        w_tok[0].nul   = i_elem.element_is_null;
        w_tok[0].last  = i_elem.last_in_array;
        w_tok[0].dupes = r_mode == adof_pkg::MODE_DUPES;
        w_tok[0].res   = 1'b0;
        w_tok[0].keep  = 1'b0;
        w_val[0]       = i_elem.element_value[VALUE_WIDTH-1:0];
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        adof_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_tok   (w_tok[g]),
            .i_val   (w_val[g]),
            .o_tok   (w_tok[g+1]),
            .o_val   (w_val[g+1])
        );
    end

    adof_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_tok   (w_tok[TABLE_DEPTH]),
        .o_vld   (w_out_vld),
        .o_res   (w_res)
    );

    assign o_res.valid            = w_out_vld;
    assign o_res.keep_element     = w_res.keep;
    assign o_res.element_position = w_res.pos;
    assign o_res.kept_so_far      = w_res.kept;
    assign o_res.array_done       = w_res.done;
    assign o_res.table_overflow   = w_res.ovf;

`ifndef SYNTHESIS
    a_keep_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.keep_element && o_res.table_overflow))
        else $error("kept word reports table overflow");

    a_kept_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ({1'b0, o_res.kept_so_far}
                         <= ({1'b0, o_res.element_position} + 17'd1)))
        else $error("kept count exceeds elements seen");

    a_ovf_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.table_overflow)
            |-> ({1'b0, o_res.element_position} >= 17'(TABLE_DEPTH)))
        else $error("overflow before table could be full");
`endif

endmodule

[design/adof_cell.sv]
// One table cell: holds a seen value and its marks, resolves passing words.
`timescale 1ns / 1ps

module adof_cell #(
    parameter int VALUE_WIDTH = adof_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  adof_pkg::t_tok         i_tok,
    input  logic [VALUE_WIDTH-1:0] i_val,
    output adof_pkg::t_tok         o_tok,
    output logic [VALUE_WIDTH-1:0] o_val
);

    logic                   r_used;
    logic                   r_once;
    logic [VALUE_WIDTH-1:0] r_val;
    adof_pkg::t_tok         r_tok;
    adof_pkg::t_tok         n_tok;
    logic [VALUE_WIDTH-1:0] r_pass;
    logic                   w_live;
    logic                   w_hit;
    logic                   w_ins;
    logic                   w_take;

    always_comb begin
        w_live = i_tok.vld && !i_tok.nul && !i_tok.res;
        w_hit  = w_live && r_used && (r_val == i_val);
        w_ins  = w_live && !r_used;
        w_take = w_hit && i_tok.dupes && r_once;
        n_tok      = i_tok;
        n_tok.res  = i_tok.res || w_hit || w_ins;
        n_tok.keep = i_tok.keep || w_take || (w_ins && !i_tok.dupes);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_once <= 1'b0;
            r_tok  <= '0;
        end else if (i_adv) begin
            r_tok <= n_tok;
            if (i_tok.vld && i_tok.last) begin
                r_used <= 1'b0;
                r_once <= 1'b0;
            end else if (w_ins) begin
                r_used <= 1'b1;
                r_once <= 1'b1;
            end else if (w_take) begin
                r_once <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pass <= i_val;
            if (w_ins) begin
                r_val <= i_val;
            end
        end
    end

    assign o_tok = r_tok;
    assign o_val = r_pass;

endmodule

[design/adof_out.sv]
// Output stage: null decisions, position and kept counters, result register.
`timescale 1ns / 1ps

module adof_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  adof_pkg::t_tok i_tok,
    output logic           o_vld,
    output adof_pkg::t_res o_res
);

    logic                r_vld;
    adof_pkg::t_res      r_res;
    adof_pkg::t_cnt      r_pos_cnt;
    adof_pkg::t_cnt      r_kept_cnt;
    adof_pkg::t_null_cnt r_null_cnt;
    adof_pkg::t_cnt      n_pos_cnt;
    adof_pkg::t_cnt      n_kept_cnt;
    adof_pkg::t_null_cnt n_null_cnt;
    logic                w_null_keep;
    logic                w_keep;
    logic                w_ovf;

    always_comb begin
        if (i_tok.dupes) begin
            w_null_keep = r_null_cnt
                == adof_pkg::t_null_cnt'(adof_pkg::NULL_KEEP_DUPES - 1);
        end else begin
            w_null_keep = r_null_cnt == '0;
        end
        w_keep = i_tok.nul ? w_null_keep : i_tok.keep;
        w_ovf  = !i_tok.nul && !i_tok.res;
        n_pos_cnt  = (r_pos_cnt != adof_pkg::CNT_MAX) ? r_pos_cnt + 1'b1 : r_pos_cnt;
        n_kept_cnt = (w_keep && r_kept_cnt != adof_pkg::CNT_MAX)
                   ? r_kept_cnt + 1'b1 : r_kept_cnt;
        n_null_cnt = (i_tok.nul
                      && r_null_cnt < adof_pkg::t_null_cnt'(adof_pkg::NULL_KEEP_DUPES))
                   ? r_null_cnt + 1'b1 : r_null_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_pos_cnt  <= '0;
            r_kept_cnt <= '0;
            r_null_cnt <= '0;
        end else if (i_adv) begin
            r_vld <= i_tok.vld;
            if (i_tok.vld) begin
                if (i_tok.last) begin
                    r_pos_cnt  <= '0;
                    r_kept_cnt <= '0;
                    r_null_cnt <= '0;
                end else begin
                    r_pos_cnt  <= n_pos_cnt;
                    r_kept_cnt <= n_kept_cnt;
                    r_null_cnt <= n_null_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_tok.vld) begin
            r_res.keep <= w_keep;
            r_res.pos  <= r_pos_cnt;
            r_res.kept <= n_kept_cnt;
            r_res.done <= i_tok.last;
            r_res.ovf  <= w_ovf;
        end
    end

    assign o_vld = r_vld;
    assign o_res = r_res;

endmodule
